[rtl/ssbi_pkg.sv]
package ssbi_pkg;

	localparam int VALUE_W = 32;
	localparam int INDEX_W = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 5;
	localparam int LIMIT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic action;
		logic signed [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0] position;
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] count;
	} result_t;

	typedef struct packed {
		logic cmp;
		logic load;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

[rtl/ssbi_cell.sv]
module ssbi_cell (
	input  logic clk,
	input  ssbi_pkg::cell_ctl_t ctl,
	input  logic valid,
	input  logic left_lt,
	input  logic signed [ssbi_pkg::VALUE_W-1:0] left_entry,
	output logic signed [ssbi_pkg::VALUE_W-1:0] entry,
	output logic lt,
	output logic eq
);
	import ssbi_pkg::*;

	logic signed [VALUE_W-1:0] entry_q;
	logic lt_q;
	logic eq_q;

	// compare pass: flag this slot against the searched word
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_q <= valid && (entry_q < ctl.value);
			eq_q <= valid && (entry_q == ctl.value);
		end
	end

	// insert pass: hold below the insert point, take the new word at it, shift up above it
	always_ff @(posedge clk) begin
		if (ctl.load && !lt_q) begin
			if (left_lt) begin
				entry_q <= ctl.value;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

	assign entry = entry_q;
	assign lt = lt_q;
	assign eq = eq_q;

endmodule

[rtl/sorted_set_binary_insert.sv]
// Each word is registered, then makes a compare pass and an insert pass through the row of
// cells; a new word is taken only once the last one has committed, and the commit waits
// while the result register is full and stalled.
// Reset (arst_n low, asynchronous): count cleared, limit_q set to 16, no result
// pending. Table contents are undefined until written; only slots below the count are read.
module sorted_set_binary_insert #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  ssbi_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output ssbi_pkg::result_t result,
	input  logic limit_valid,
	output logic limit_ready,
	input  logic [ssbi_pkg::LIMIT_W-1:0] limit_data
);
	import ssbi_pkg::*;

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int PXW = PW + INDEX_W;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMP = 2'd1;
	localparam logic [1:0] PH_COMMIT = 2'd2;

	logic [1:0] phase_q;
	item_t item_q;
	logic [CW-1:0] fill_q;
	logic [LIMIT_W-1:0] limit_q;
	result_t result_q;
	logic result_valid_q;

	cell_ctl_t ctl;
	logic signed [VALUE_W-1:0] entry [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] left_lt;
	logic [CAPACITY-1:0] boundary;
	logic [CAPACITY-1:0] valid;

	logic [PW-1:0] pos_enc;
	logic [PXW-1:0] pos_wide;
	logic found;
	logic full;
	logic ins_ok;
	logic commit;
	logic [LW-1:0] fill_ext;
	logic [LW-1:0] count_ext;
	logic signed [VALUE_W-1:0] rd;
	result_t res_next;

	assign item_stall = (phase_q != PH_IDLE);
	assign limit_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign commit = (phase_q == PH_COMMIT) && (!result_valid_q || !result_stall);

	assign ctl.cmp = (phase_q == PH_CMP);
	assign ctl.load = commit && ins_ok;
	assign ctl.value = item_q.value;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			assign valid[g] = CW'(g) < fill_q;
			if (g == 0) begin : g_head
				assign left_lt[g] = 1'b1;
				ssbi_cell u_cell (
					.clk(clk), .ctl(ctl), .valid(valid[g]),
					.left_lt(1'b1), .left_entry('0),
					.entry(entry[g]), .lt(lt[g]), .eq(eq[g])
				);
			end else begin : g_body
				assign left_lt[g] = lt[g-1];
				ssbi_cell u_cell (
					.clk(clk), .ctl(ctl), .valid(valid[g]),
					.left_lt(lt[g-1]), .left_entry(entry[g-1]),
					.entry(entry[g]), .lt(lt[g]), .eq(eq[g])
				);
			end
		end
	endgenerate

	assign boundary = left_lt & ~lt;

	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (boundary[i]) begin
				pos_enc = pos_enc | PW'(i);
			end
		end
	end

	always_comb begin
		rd = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (i < 16 && item_q.index == INDEX_W'(i)) begin
				rd = entry[i];
			end
		end
	end

	assign pos_wide = PXW'(pos_enc);
	assign found = |eq;
	assign fill_ext = LW'(fill_q);
	assign full = (fill_ext >= LW'(limit_q)) || (fill_q == CW'(CAPACITY));
	assign ins_ok = (item_q.action == ACT_INSERT) && !found && !full;
	assign count_ext = ins_ok ? LW'(fill_q + 1'b1) : fill_ext;

	always_comb begin
		res_next.status = ST_DONE;
		res_next.position = '0;
		res_next.read_value = '0;
		res_next.count = count_ext[COUNT_W-1:0];
		if (item_q.action == ACT_READ) begin
			if (LW'(item_q.index) >= fill_ext) begin
				res_next.status = ST_BADIDX;
			end else begin
				res_next.read_value = rd;
			end
		end else if (found) begin
			res_next.status = ST_DUP;
			res_next.position = pos_wide[INDEX_W-1:0];
		end else if (full) begin
			res_next.status = ST_FULL;
		end else begin
			res_next.position = pos_wide[INDEX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fill_q <= '0;
			limit_q <= LIMIT_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (limit_valid && limit_ready) begin
				limit_q <= limit_data;
			end
			if (result_valid_q && !result_stall && !commit) begin
				result_valid_q <= 1'b0;
			end
			case (phase_q)
				PH_IDLE: begin
					if (item_valid) begin
						phase_q <= PH_CMP;
					end
				end
				PH_CMP: begin
					phase_q <= PH_COMMIT;
				end
				PH_COMMIT: begin
					// hold until the result register is free
					if (commit) begin
						phase_q <= PH_IDLE;
						result_valid_q <= 1'b1;
						if (ins_ok) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_q <= item;
		end
		if (commit) begin
			result_q <= res_next;
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_eq_single: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COMMIT) |-> $onehot0(eq))
		else $error("value matched in more than one slot");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == CW'($past(fill_q) + 1'b1)))
		else $error("fill count moved by other than one");

	a_commit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> ##1 (phase_q == PH_COMMIT))
		else $error("compare pass skipped");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && fill_q >= CW'(2)) |-> (entry[0] < entry[1]))
		else $error("head of table out of order");
`endif

endmodule

[verif/sorted_set_binary_insert_tb.sv]
`timescale 1ns / 1ps

module sorted_set_binary_insert_tb;
	import ssbi_pkg::*;

	localparam int CAPACITY = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_WORDS = 255;
	localparam int CALM_WORDS = 200;

	typedef enum logic {ROW_WORD, ROW_LIMIT} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [LIMIT_W-1:0] limit;
		item_t w;
		bit pinned;
		result_t want;
	} dir_row_t;

	typedef struct {
		bit pinned;
		result_t want;
	} pin_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic limit_valid;
	logic limit_ready;
	logic [LIMIT_W-1:0] limit_data;

	// shadow copy of the table, the count and the limit register
	logic signed [VALUE_W-1:0] shadow_vals [CAPACITY];
	int unsigned shadow_count;
	int unsigned shadow_limit;

	result_t due_results[$];
	pin_t pinned_results[$];
	dir_row_t dir_rows[$];
	int fail_count;
	int cycles;
	int words_left;
	bit calm;
	int stall_hold;

	sorted_set_binary_insert #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.limit_valid(limit_valid),
		.limit_ready(limit_ready),
		.limit_data(limit_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// read a slot, or search, then either report or shift the upper entries and place the value
	function automatic result_t set_apply(item_t w);
		result_t r;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned lim;
		int unsigned i;
		bit found;
		r = '0;
		r.status = ST_DONE;
		if (w.action == ACT_READ) begin
			if (int'(w.index) < shadow_count) begin
				r.read_value = shadow_vals[w.index];
			end else begin
				r.status = ST_BADIDX;
			end
		end else begin
			lo = 0;
			hi = shadow_count;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if ($signed(shadow_vals[mid]) < $signed(w.value))
					lo = mid + 1;
				else
					hi = mid;
			end
			found = (lo < shadow_count) && (shadow_vals[lo] == w.value);
			lim = (shadow_limit > CAPACITY) ? CAPACITY : shadow_limit;
			if (found) begin
				r.status = ST_DUP;
				r.position = INDEX_W'(lo);
			end else if (shadow_count >= lim) begin
				r.status = ST_FULL;
			end else begin
				for (i = shadow_count; i > lo; i--)
					shadow_vals[i] = shadow_vals[i - 1];
				shadow_vals[lo] = w.value;
				shadow_count++;
				r.position = INDEX_W'(lo);
			end
		end
		r.count = COUNT_W'(shadow_count);
		return r;
	endfunction

	task automatic check_result(result_t got, result_t want);
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.position !== want.position) begin
			$error("position: expected %0d, got %0d", want.position, got.position);
			fail_count++;
		end
		if (got.read_value !== want.read_value) begin
			$error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
			fail_count++;
		end
		if (got.count !== want.count) begin
			$error("count: expected %0d, got %0d", want.count, got.count);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		pin_t p;
		result_t pred;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else if (arst_n) begin
			if (limit_valid && limit_ready)
				shadow_limit = 32'(limit_data);
			if (item_valid && !item_stall) begin
				pred = set_apply(item);
				p = pinned_results.pop_front();
				due_results.push_back(p.pinned ? p.want : pred);
			end
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					check_result(result, due_results.pop_front());
				end
			end
		end
	end

	// receiver: random stretches of stall and of open flow, none once calm
	always @(posedge clk) begin
		if (calm) begin
			result_stall <= 1'b0;
		end else if (stall_hold == 0) begin
			result_stall <= ($urandom_range(0, 2) == 0);
			stall_hold = $urandom_range(1, 15);
		end else begin
			stall_hold--;
		end
	end

	task automatic add_item(logic act, logic [VALUE_W-1:0] val, logic [INDEX_W-1:0] idx,
			bit pinned, logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] pos,
			logic [VALUE_W-1:0] rd, logic [COUNT_W-1:0] cnt);
		dir_row_t row;
		row.kind = ROW_WORD;
		row.limit = '0;
		row.w.action = act;
		row.w.value = val;
		row.w.index = idx;
		row.pinned = pinned;
		row.want.status = st;
		row.want.position = pos;
		row.want.read_value = rd;
		row.want.count = cnt;
		dir_rows.push_back(row);
	endtask

	task automatic add_limit(logic [LIMIT_W-1:0] v);
		dir_row_t row;
		row.kind = ROW_LIMIT;
		row.limit = v;
		row.w = '0;
		row.pinned = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	task automatic send_word(item_t w, bit pinned, result_t want);
		pin_t p;
		p.pinned = pinned;
		p.want = want;
		pinned_results.push_back(p);
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic pause_maybe();
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// write the limit only once the block has drained
	task automatic set_limit(logic [LIMIT_W-1:0] v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		limit_data <= v;
		limit_valid <= 1'b1;
		do @(posedge clk); while (!limit_ready);
		limit_valid <= 1'b0;
	endtask

	function automatic item_t random_word();
		item_t w;
		int pick;
		w.action = ($urandom_range(0, 9) < 4) ? ACT_READ : ACT_INSERT;
		w.value = $urandom;
		w.index = INDEX_W'($urandom_range(0, 15));
		if (w.action == ACT_INSERT && shadow_count != 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				w.value = shadow_vals[$urandom_range(0, shadow_count - 1)];
			else if (pick == 4)
				w.value = shadow_vals[$urandom_range(0, shadow_count - 1)]
					+ ($urandom_range(0, 1) ? 1 : -1);
			else if (pick == 5)
				case ($urandom_range(0, 3))
					0: w.value = 32'sh8000_0000;
					1: w.value = 32'sh7fff_ffff;
					2: w.value = 0;
					default: w.value = -1;
				endcase
		end
		return w;
	endfunction

	initial begin
		result_t none;
		int lim;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		limit_valid = 1'b0;
		limit_data = '0;
		fail_count = 0;
		cycles = 0;
		calm = 1'b0;
		stall_hold = 0;
		shadow_count = 0;
		shadow_limit = 32'(LIMIT_RESET);
		foreach (shadow_vals[i])
			shadow_vals[i] = '0;
		none = '0;

		// empty table, then extremes and sorted placement
		add_item(ACT_READ, 32'hffff_ffff, 4'd0, 1, ST_BADIDX, 0, 0, 0);
		add_item(ACT_READ, 32'h0, 4'd15, 1, ST_BADIDX, 0, 0, 0);
		add_item(ACT_INSERT, 32'h0, 4'd15, 1, ST_DONE, 0, 0, 1);
		add_item(ACT_INSERT, 32'h8000_0000, 4'd0, 1, ST_DONE, 0, 0, 2);
		add_item(ACT_INSERT, 32'h7fff_ffff, 4'd0, 1, ST_DONE, 2, 0, 3);
		add_item(ACT_INSERT, 32'h0, 4'd0, 1, ST_DUP, 1, 0, 3);
		add_item(ACT_READ, 32'h0, 4'd0, 1, ST_DONE, 0, 32'h8000_0000, 3);
		add_item(ACT_READ, 32'h0, 4'd2, 1, ST_DONE, 0, 32'h7fff_ffff, 3);
		add_item(ACT_READ, 32'h0, 4'd3, 1, ST_BADIDX, 0, 0, 3);
		add_item(ACT_INSERT, 32'hffff_ffff, 4'd0, 0, ST_DONE, 0, 0, 0);
		add_item(ACT_INSERT, 32'h1, 4'd0, 0, ST_DONE, 0, 0, 0);
		add_item(ACT_INSERT, 32'h5555_5555, 4'd0, 0, ST_DONE, 0, 0, 0);
		add_item(ACT_INSERT, 32'haaaa_aaaa, 4'd0, 0, ST_DONE, 0, 0, 0);
		add_item(ACT_READ, 32'h0, 4'd1, 0, ST_DONE, 0, 0, 0);
		// limit under the count: new values full, present values still found
		add_limit(5'd2);
		add_item(ACT_INSERT, 32'h5, 4'd0, 1, ST_FULL, 0, 0, 7);
		add_item(ACT_INSERT, 32'h1, 4'd0, 1, ST_DUP, 4, 0, 7);
		add_limit(5'd0);
		add_item(ACT_INSERT, 32'h7, 4'd0, 1, ST_FULL, 0, 0, 7);
		add_item(ACT_INSERT, 32'h7fff_ffff, 4'd0, 1, ST_DUP, 6, 0, 7);
		add_item(ACT_INSERT, 32'h8000_0000, 4'd0, 1, ST_DUP, 0, 0, 7);
		// limit past the table size acts as the table size
		add_limit(5'd31);
		add_item(ACT_INSERT, 32'd100, 4'd0, 0, ST_DONE, 0, 0, 0);
		add_item(ACT_INSERT, -32'sd100, 4'd0, 0, ST_DONE, 0, 0, 0);
		add_item(ACT_READ, 32'h0, 4'd15, 0, ST_DONE, 0, 0, 0);
		add_limit(5'd9);
		add_item(ACT_INSERT, 32'd42, 4'd0, 0, ST_DONE, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_LIMIT) begin
				set_limit(dir_rows[r].limit);
			end else begin
				send_word(dir_rows[r].w, dir_rows[r].pinned, dir_rows[r].want);
				pause_maybe();
			end
		end

		words_left = RAND_PHASES * PHASE_WORDS;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: lim = 16;
				1: lim = 31;
				2: lim = 0;
				default: lim = $urandom_range(0, 31);
			endcase
			set_limit(LIMIT_W'(lim));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (words_left <= CALM_WORDS)
					calm = 1'b1;
				send_word(random_word(), 1'b0, none);
				words_left--;
				pause_maybe();
			end
		end
		item_valid <= 1'b0;

		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
